// ===== sv/lzwd_pkg.sv =====
// shared types, constants and state codes for the lzw code decoder
package lzwd_pkg;

	localparam int DICT_ENTRIES_DEF = 4096;
	localparam int MAX_STRING_DEF   = 64;
	localparam int CODE_W           = 12;
	localparam int BYTE_W           = 8;
	localparam int LEN_W            = 7;
	localparam int NEXT_W           = 13;
	localparam int ROOTS            = 256;
	localparam int CODE_LIMIT       = 4096;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              final_code;
	} code_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
		logic              error;
	} sym_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] prefix;
		logic [BYTE_W-1:0] sym;
		logic [LEN_W-1:0]  len;
	} dict_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_WALK,
		ST_UPDATE,
		ST_EMIT,
		ST_ERROR
	} state_t;

endpackage

// ===== sv/lzwd_dict.sv =====
// dictionary memory: prefix code, final byte and length per code
module lzwd_dict
	import lzwd_pkg::*;
#(
	parameter int DEPTH = DICT_ENTRIES_DEF - ROOTS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [AW-1:0] wr_addr,
	input  dict_entry_t wr_data,
	input  logic        rd_en,
	input  logic [AW-1:0] rd_addr,
	output dict_entry_t rd_data
);

	dict_entry_t mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/lzwd_stack.sv =====
// unwind stack memory holding one decoded string in output order
module lzwd_stack
	import lzwd_pkg::*;
#(
	parameter int DEPTH = MAX_STRING_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/lzw_code_decoder_top.sv =====
// LZW code decoder: one code in, its decoded string out one byte per transaction
//
// Takes one 12-bit LZW code per input transaction (256 single-byte roots) and
// returns the decoded string one byte per output transaction, with last set on
// the final byte. An invalid code, an overlong string, or any code after an
// error gives a single result with error and last set and a zero byte; the
// stream stays failed until the code marked final_code has been taken, after
// which the dictionary starts afresh. One code is worked on at a time: the
// prefix chain is walked one dictionary entry at a time (address out in
// READ, registered read data back in WALK), and the bytes then leave the
// unwind stack at one per cycle while the output does not stall. An error
// found on the code itself goes straight from the check to the error result;
// an overlong string is found in the check or on the first dictionary read.
// The next code can be taken once the last byte is registered into the output.
// The dictionary needs no clearing after reset: only entries written in the
// current stream are ever read.
module lzw_code_decoder_top
	import lzwd_pkg::*;
#(
	parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
	parameter int MAX_STRING   = MAX_STRING_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       code_valid,
	output logic       code_stall,
	input  code_item_t code_item,
	output logic       sym_valid,
	input  logic       sym_stall,
	output sym_item_t  sym_item
);

	localparam int GROW_LIMIT = (DICT_ENTRIES < CODE_LIMIT) ? DICT_ENTRIES : CODE_LIMIT;
	localparam int DICT_DEPTH = GROW_LIMIT - ROOTS;
	localparam int DAW        = $clog2(DICT_DEPTH);
	localparam int SAW        = $clog2(MAX_STRING);
	localparam logic [NEXT_W-1:0] GROW_LIMIT_NF = NEXT_W'(GROW_LIMIT);
	localparam logic [NEXT_W-1:0] ROOTS_NF      = NEXT_W'(ROOTS);
	localparam logic [CODE_W-1:0] ROOTS_C       = CODE_W'(ROOTS);
	localparam logic [LEN_W-1:0]  MAX_LEN       = LEN_W'(MAX_STRING);
	localparam logic [LEN_W-1:0]  MAX_LEN_SAT   = LEN_W'(MAX_STRING + 1);
	localparam logic [LEN_W-1:0]  LEN_ONE       = LEN_W'(1);

	state_t state_q, state_n;

	// stream state
	logic [NEXT_W-1:0] next_free_q;
	logic [CODE_W-1:0] prev_q;
	logic [LEN_W-1:0]  prev_len_q;
	logic              have_prev_q;
	logic              failed_q;

	// per-code working registers
	logic [CODE_W-1:0] code_q;
	logic              fin_q;
	logic [CODE_W-1:0] cur_q;
	logic              kwk_q;
	logic              first_q;
	logic [LEN_W-1:0]  len_q;
	logic [SAW-1:0]    pos_q;
	logic [BYTE_W-1:0] first_byte_q;
	logic [SAW-1:0]    k_q;

	// output register
	logic      sym_valid_q;
	sym_item_t sym_item_q;

	// memory ports
	logic              dict_wr_en, dict_rd_en;
	logic [DAW-1:0]    dict_wr_addr, dict_rd_addr;
	dict_entry_t       dict_wr_data, dict_rd_data;
	logic              stk_wr_en, stk_rd_en;
	logic [SAW-1:0]    stk_wr_addr, stk_rd_addr;
	logic [BYTE_W-1:0] stk_wr_data, stk_rd_data;

	// decode conditions
	logic              full, is_kwk, chk_err, walk_err, cur_root, ofree;
	logic              emit_last, add_entry;
	logic [LEN_W-1:0]  prev_len_inc, walk_len, new_len;
	logic [SAW-1:0]    walk_pos;
	logic [BYTE_W-1:0] emit_byte;

	assign full         = next_free_q >= GROW_LIMIT_NF;
	assign is_kwk       = {1'b0, code_q} == next_free_q;
	assign prev_len_inc = prev_len_q + LEN_ONE;
	assign chk_err      = failed_q
		|| (!have_prev_q && code_q >= ROOTS_C)
		|| (have_prev_q && ({1'b0, code_q} > next_free_q))
		|| (have_prev_q && is_kwk && full)
		|| (have_prev_q && is_kwk && prev_len_inc > MAX_LEN);
	assign cur_root     = cur_q < ROOTS_C;
	assign walk_len     = first_q ? dict_rd_data.len : len_q;
	assign walk_pos     = first_q ? SAW'(dict_rd_data.len - LEN_ONE) : pos_q;
	assign walk_err     = first_q && (dict_rd_data.len > MAX_LEN);
	assign ofree        = !sym_valid_q || !sym_stall;
	assign emit_last    = ({{(LEN_W-SAW){1'b0}}, k_q} + LEN_ONE) == len_q;
	assign emit_byte    = (emit_last && kwk_q) ? first_byte_q : stk_rd_data;
	assign add_entry    = have_prev_q && !full;
	assign new_len      = (prev_len_inc > MAX_LEN_SAT) ? MAX_LEN_SAT : prev_len_inc;

	// memory addressing and data
	assign dict_rd_addr = DAW'(cur_q - ROOTS_C);
	assign dict_wr_addr = DAW'(next_free_q - ROOTS_NF);
	assign dict_wr_data = '{prefix: prev_q, sym: first_byte_q, len: new_len};
	assign stk_wr_addr  = (state_q == ST_WALK) ? walk_pos : pos_q;
	assign stk_wr_data  = (state_q == ST_WALK) ? dict_rd_data.sym : cur_q[BYTE_W-1:0];
	assign stk_rd_addr  = (state_q == ST_EMIT) ? SAW'(k_q + SAW'(1)) : '0;

	// sequencer: next state and memory strobes
	always_comb begin
		state_n    = state_q;
		code_stall = 1'b1;
		dict_rd_en = 1'b0;
		dict_wr_en = 1'b0;
		stk_wr_en  = 1'b0;
		stk_rd_en  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				code_stall = 1'b0;
				if (code_valid) begin
					state_n = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_n = chk_err ? ST_ERROR : ST_READ;
			end
			ST_READ: begin
				if (cur_root) begin
					stk_wr_en = 1'b1;
					state_n   = ST_UPDATE;
				end else begin
					dict_rd_en = 1'b1;
					state_n    = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_err) begin
					state_n = ST_ERROR;
				end else begin
					stk_wr_en = 1'b1;
					state_n   = ST_READ;
				end
			end
			ST_UPDATE: begin
				dict_wr_en = add_entry;
				stk_rd_en  = 1'b1;
				state_n    = ST_EMIT;
			end
			ST_EMIT: begin
				if (ofree) begin
					if (emit_last) begin
						state_n = ST_IDLE;
					end else begin
						stk_rd_en = 1'b1;
					end
				end
			end
			ST_ERROR: begin
				if (ofree) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_free_q <= ROOTS_NF;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			failed_q    <= 1'b0;
			sym_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_UPDATE) begin
				if (add_entry) begin
					next_free_q <= next_free_q + NEXT_W'(1);
				end
				prev_q      <= code_q;
				have_prev_q <= 1'b1;
			end
			if (state_q == ST_ERROR && ofree && !fin_q) begin
				failed_q <= 1'b1;
			end
			// final code: stream returns to its starting point
			if (fin_q && ((state_q == ST_ERROR && ofree)
				|| (state_q == ST_EMIT && ofree && emit_last))) begin
				next_free_q <= ROOTS_NF;
				prev_q      <= '0;
				have_prev_q <= 1'b0;
				failed_q    <= 1'b0;
			end
			// output register
			if ((state_q == ST_EMIT || state_q == ST_ERROR) && ofree) begin
				sym_valid_q <= 1'b1;
			end else if (!sym_stall) begin
				sym_valid_q <= 1'b0;
			end
		end
	end

	// working registers and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (code_valid) begin
					code_q <= code_item.code;
					fin_q  <= code_item.final_code;
				end
			end
			ST_CHECK: begin
				kwk_q <= have_prev_q && is_kwk;
				if (have_prev_q && is_kwk) begin
					cur_q   <= prev_q;
					len_q   <= prev_len_inc;
					pos_q   <= SAW'(prev_len_q - LEN_ONE);
					first_q <= 1'b0;
				end else begin
					cur_q   <= code_q;
					len_q   <= LEN_ONE;
					pos_q   <= '0;
					first_q <= code_q >= ROOTS_C;
				end
			end
			ST_READ: begin
				first_byte_q <= cur_q[BYTE_W-1:0];
			end
			ST_WALK: begin
				len_q   <= walk_len;
				pos_q   <= walk_pos - SAW'(1);
				cur_q   <= dict_rd_data.prefix;
				first_q <= 1'b0;
			end
			ST_UPDATE: begin
				prev_len_q <= len_q;
				k_q        <= '0;
			end
			ST_EMIT: begin
				if (ofree) begin
					sym_item_q <= '{out_byte: emit_byte, last: emit_last, error: 1'b0};
					k_q        <= k_q + SAW'(1);
				end
			end
			ST_ERROR: begin
				if (ofree) begin
					sym_item_q <= '{out_byte: '0, last: 1'b1, error: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	assign sym_valid = sym_valid_q;
	assign sym_item  = sym_item_q;

	// dictionary
	lzwd_dict #(
		.DEPTH(DICT_DEPTH)
	) u_dict (
		.clk    (clk),
		.wr_en  (dict_wr_en),
		.wr_addr(dict_wr_addr),
		.wr_data(dict_wr_data),
		.rd_en  (dict_rd_en),
		.rd_addr(dict_rd_addr),
		.rd_data(dict_rd_data)
	);

	// unwind stack
	lzwd_stack #(
		.DEPTH(MAX_STRING)
	) u_stack (
		.clk    (clk),
		.wr_en  (stk_wr_en),
		.wr_addr(stk_wr_addr),
		.wr_data(stk_wr_data),
		.rd_en  (stk_rd_en),
		.rd_addr(stk_rd_addr),
		.rd_data(stk_rd_data)
	);

	// error results are always a single zero byte closing the string
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(sym_valid && sym_item.error) |-> (sym_item.out_byte == '0 && sym_item.last))
		else $error("error result with nonzero byte or without last");

	// next free code stays between the roots and the growth limit
	a_next_free: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q >= ROOTS_NF) && (next_free_q <= GROW_LIMIT_NF))
		else $error("next free code out of range");

	// finishing the final code leaves a clean stream
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_n == ST_IDLE && fin_q)
		|=> (next_free_q == ROOTS_NF && !have_prev_q && !failed_q))
		else $error("stream not cleared after final code");

endmodule
